@@ rtl/bounded_deque_with_sorted_insert_macros.svh @@
// Assertion macros for the bounded deque with sorted insert.
// Used by the top level; expects clk and rst_n in scope where expanded.
`ifndef BOUNDED_DEQUE_WITH_SORTED_INSERT_MACROS_SVH
`define BOUNDED_DEQUE_WITH_SORTED_INSERT_MACROS_SVH

// Check a condition at every clock edge out of reset
`define BDQ_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check a consequence in the same cycle as its trigger
`define BDQ_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the cycle after its trigger
`define BDQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/bdq_pkg.sv @@
// Shared types and constants for the bounded deque with sorted insert.
// No dependencies; imported by the top level and the testbench.
package bdq_pkg;

    localparam int BDQ_DEPTH_DEF      = 16;
    localparam int BDQ_DATA_WIDTH_DEF = 32;

    localparam int CMD_W    = 3;
    localparam int STATUS_W = 2;

    typedef logic [CMD_W-1:0]    cmd_t;
    typedef logic [STATUS_W-1:0] status_t;

    // Command codes
    localparam cmd_t CMD_PUSH_FRONT = 3'd0;
    localparam cmd_t CMD_PUSH_BACK  = 3'd1;
    localparam cmd_t CMD_POP_FRONT  = 3'd2;
    localparam cmd_t CMD_POP_BACK   = 3'd3;
    localparam cmd_t CMD_SORTED     = 3'd4;

    // Result status codes
    localparam status_t ST_DONE  = 2'd0;
    localparam status_t ST_EMPTY = 2'd1;
    localparam status_t ST_FULL  = 2'd2;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_ALLOC,
        S_WALK,
        S_LINK,
        S_POP,
        S_FINISH
    } state_t;

endpackage

@@ rtl/bdq_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies; used for every store of the deque.
module bdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/bdq_cmp.sv @@
// Shared signed less-than comparator used on every step of the ordered walk.
// No dependencies.
module bdq_cmp #(
    parameter int WIDTH = 32
) (
    input  logic signed [WIDTH-1:0] a,
    input  logic signed [WIDTH-1:0] b,
    output logic                    lt
);

    // Signed less-than
    assign lt = (a < b);

endmodule

@@ rtl/bounded_deque_with_sorted_insert.sv @@
// Sequence: a push or pop passes S_ALLOC or S_POP, then S_FINISH; a rejected or unknown
// command goes straight to S_FINISH. A sorted insert into a non-empty list walks from the
// front in S_WALK after S_ALLOC and, when it lands between two entries, links in S_LINK.
// Flow: a new command is taken only in S_IDLE, after the last result is registered; a held
// result stalls the sequencer in its last state. The insert walk reads the value and link
// RAMs one entry per cycle through a single shared comparator.
// Reset: control state cleared asynchronously; list stores are not cleared (no sweep).
// Depends on bdq_pkg, bdq_ram, bdq_cmp and the assertion macro header.
`include "bounded_deque_with_sorted_insert_macros.svh"

module bounded_deque_with_sorted_insert
    import bdq_pkg::*;
#(
    parameter int DEPTH      = BDQ_DEPTH_DEF,
    parameter int DATA_WIDTH = BDQ_DATA_WIDTH_DEF,
    localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW        = $clog2(DEPTH + 1),
    localparam int IN_W      = ((CMD_W + DATA_WIDTH + 7) / 8) * 8,
    localparam int OUT_W     = ((STATUS_W + DATA_WIDTH + CW + 7) / 8) * 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // cmd, value, zero pad
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata    // status, removed_value, count, zero pad
);

    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    // Sequencer and list registers
    state_t                 state_reg, state_next;
    cmd_t                   cmd_reg, cmd_next;
    logic [DATA_WIDTH-1:0]  value_reg, value_next;
    logic [AW-1:0]          slot_reg, slot_next;
    logic [AW-1:0]          cur_reg, cur_next;
    logic [AW-1:0]          before_reg, before_next;
    logic                   have_before_reg, have_before_next;
    logic [CW-1:0]          steps_reg, steps_next;
    logic [AW-1:0]          head_reg, head_next;
    logic [AW-1:0]          tail_reg, tail_next;
    logic [CW-1:0]          count_reg, count_next;
    logic [CW-1:0]          fresh_reg, fresh_next;
    logic [CW-1:0]          fstk_reg, fstk_next;
    logic                   use_stack_reg, use_stack_next;
    status_t                res_status_reg, res_status_next;
    logic [DATA_WIDTH-1:0]  res_removed_reg, res_removed_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [OUT_W-1:0]       m_tdata_reg, m_tdata_next;

    // RAM ports
    logic                  val_we, nxt_we, prv_we, free_we;
    logic [AW-1:0]         val_waddr, nxt_waddr, prv_waddr, free_waddr;
    logic [DATA_WIDTH-1:0] val_wdata;
    logic [AW-1:0]         nxt_wdata, prv_wdata, free_wdata;
    logic [AW-1:0]         val_raddr, nxt_raddr, prv_raddr, free_raddr;
    logic [DATA_WIDTH-1:0] val_rdata;
    logic [AW-1:0]         nxt_rdata, prv_rdata, free_rdata;

    // Helpers
    cmd_t                  in_cmd;
    logic [DATA_WIDTH-1:0] in_value;
    logic                  in_xfer;
    logic                  lt;
    logic [AW-1:0]         slot_w;
    logic [AW-1:0]         pop_slot;
    logic [CW-1:0]         fstk_dec;
    logic [CW-1:0]         steps_inc;

    assign in_cmd    = s_tdata[CMD_W-1:0];
    assign in_value  = s_tdata[CMD_W +: DATA_WIDTH];
    assign s_tready  = (state_reg == S_IDLE);
    assign in_xfer   = s_tvalid && s_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign slot_w    = use_stack_reg ? free_rdata : slot_reg;
    assign pop_slot  = (in_cmd == CMD_POP_FRONT) ? head_reg : tail_reg;
    assign fstk_dec  = fstk_reg - 1'b1;
    assign steps_inc = steps_reg + 1'b1;

    // Stores
    bdq_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DEPTH)) u_val_ram (
        .clk(clk), .we(val_we), .waddr(val_waddr), .wdata(val_wdata),
        .raddr(val_raddr), .rdata(val_rdata)
    );

    bdq_ram #(.WIDTH(AW), .DEPTH(DEPTH)) u_nxt_ram (
        .clk(clk), .we(nxt_we), .waddr(nxt_waddr), .wdata(nxt_wdata),
        .raddr(nxt_raddr), .rdata(nxt_rdata)
    );

    bdq_ram #(.WIDTH(AW), .DEPTH(DEPTH)) u_prv_ram (
        .clk(clk), .we(prv_we), .waddr(prv_waddr), .wdata(prv_wdata),
        .raddr(prv_raddr), .rdata(prv_rdata)
    );

    bdq_ram #(.WIDTH(AW), .DEPTH(DEPTH)) u_free_ram (
        .clk(clk), .we(free_we), .waddr(free_waddr), .wdata(free_wdata),
        .raddr(free_raddr), .rdata(free_rdata)
    );

    // Shared comparator for the ordered walk
    bdq_cmp #(.WIDTH(DATA_WIDTH)) u_cmp (
        .a (val_rdata),
        .b (value_reg),
        .lt(lt)
    );

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            fresh_reg     <= '0;
            fstk_reg      <= '0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            fresh_reg     <= fresh_next;
            fstk_reg      <= fstk_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg         <= cmd_next;
        value_reg       <= value_next;
        slot_reg        <= slot_next;
        cur_reg         <= cur_next;
        before_reg      <= before_next;
        have_before_reg <= have_before_next;
        steps_reg       <= steps_next;
        use_stack_reg   <= use_stack_next;
        res_status_reg  <= res_status_next;
        res_removed_reg <= res_removed_next;
        m_tdata_reg     <= m_tdata_next;
    end

    // Sequencer: next state, list updates and RAM accesses
    always_comb
    begin
        state_next       = state_reg;
        cmd_next         = cmd_reg;
        value_next       = value_reg;
        slot_next        = slot_reg;
        cur_next         = cur_reg;
        before_next      = before_reg;
        have_before_next = have_before_reg;
        steps_next       = steps_reg;
        head_next        = head_reg;
        tail_next        = tail_reg;
        count_next       = count_reg;
        fresh_next       = fresh_reg;
        fstk_next        = fstk_reg;
        use_stack_next   = use_stack_reg;
        res_status_next  = res_status_reg;
        res_removed_next = res_removed_reg;
        m_tdata_next     = m_tdata_reg;
        m_tvalid_next    = m_tvalid_reg && !m_tready;

        val_we     = 1'b0;
        val_waddr  = '0;
        val_wdata  = '0;
        val_raddr  = '0;
        nxt_we     = 1'b0;
        nxt_waddr  = '0;
        nxt_wdata  = '0;
        nxt_raddr  = '0;
        prv_we     = 1'b0;
        prv_waddr  = '0;
        prv_wdata  = '0;
        prv_raddr  = '0;
        free_we    = 1'b0;
        free_waddr = '0;
        free_wdata = '0;
        free_raddr = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    cmd_next         = in_cmd;
                    value_next       = in_value;
                    res_status_next  = ST_DONE;
                    res_removed_next = '0;
                    state_next       = S_FINISH;
                    if (in_cmd inside {CMD_PUSH_FRONT, CMD_PUSH_BACK, CMD_SORTED})
                    begin
                        if (count_reg == DEPTH_C)
                        begin
                            res_status_next = ST_FULL;
                        end
                        else if (fstk_reg != '0)
                        begin
                            // Reuse a freed slot from the stack
                            free_raddr     = fstk_dec[AW-1:0];
                            fstk_next      = fstk_dec;
                            use_stack_next = 1'b1;
                            state_next     = S_ALLOC;
                        end
                        else
                        begin
                            // Take a never-used slot
                            slot_next      = fresh_reg[AW-1:0];
                            fresh_next     = fresh_reg + 1'b1;
                            use_stack_next = 1'b0;
                            state_next     = S_ALLOC;
                        end
                    end
                    else if (in_cmd inside {CMD_POP_FRONT, CMD_POP_BACK})
                    begin
                        if (count_reg == '0)
                        begin
                            res_status_next = ST_EMPTY;
                        end
                        else
                        begin
                            slot_next  = pop_slot;
                            val_raddr  = pop_slot;
                            nxt_raddr  = pop_slot;
                            prv_raddr  = pop_slot;
                            state_next = S_POP;
                        end
                    end
                end
            end

            S_ALLOC:
            begin
                slot_next  = slot_w;
                val_we     = 1'b1;
                val_waddr  = slot_w;
                val_wdata  = value_reg;
                state_next = S_FINISH;
                case (cmd_reg)
                    CMD_PUSH_FRONT:
                    begin
                        if (count_reg == '0)
                        begin
                            tail_next = slot_w;
                        end
                        else
                        begin
                            nxt_we    = 1'b1;
                            nxt_waddr = slot_w;
                            nxt_wdata = head_reg;
                            prv_we    = 1'b1;
                            prv_waddr = head_reg;
                            prv_wdata = slot_w;
                        end
                        head_next  = slot_w;
                        count_next = count_reg + 1'b1;
                    end

                    CMD_PUSH_BACK:
                    begin
                        if (count_reg == '0)
                        begin
                            head_next = slot_w;
                        end
                        else
                        begin
                            prv_we    = 1'b1;
                            prv_waddr = slot_w;
                            prv_wdata = tail_reg;
                            nxt_we    = 1'b1;
                            nxt_waddr = tail_reg;
                            nxt_wdata = slot_w;
                        end
                        tail_next  = slot_w;
                        count_next = count_reg + 1'b1;
                    end

                    CMD_SORTED:
                    begin
                        if (count_reg == '0)
                        begin
                            head_next  = slot_w;
                            tail_next  = slot_w;
                            count_next = count_reg + 1'b1;
                        end
                        else
                        begin
                            // Start the walk at the front
                            val_raddr        = head_reg;
                            nxt_raddr        = head_reg;
                            cur_next         = head_reg;
                            steps_next       = '0;
                            have_before_next = 1'b0;
                            state_next       = S_WALK;
                        end
                    end

                    default:
                    begin
                        state_next = S_FINISH;
                    end
                endcase
            end

            S_WALK:
            begin
                if (lt)
                begin
                    before_next      = cur_reg;
                    have_before_next = 1'b1;
                    if (steps_inc == count_reg)
                    begin
                        // Ran off the back: append
                        prv_we     = 1'b1;
                        prv_waddr  = slot_reg;
                        prv_wdata  = tail_reg;
                        nxt_we     = 1'b1;
                        nxt_waddr  = tail_reg;
                        nxt_wdata  = slot_reg;
                        tail_next  = slot_reg;
                        count_next = count_reg + 1'b1;
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        // Advance to the next entry
                        cur_next   = nxt_rdata;
                        val_raddr  = nxt_rdata;
                        nxt_raddr  = nxt_rdata;
                        steps_next = steps_inc;
                    end
                end
                else if (!have_before_reg)
                begin
                    // Smallest so far: link at the front
                    nxt_we     = 1'b1;
                    nxt_waddr  = slot_reg;
                    nxt_wdata  = head_reg;
                    prv_we     = 1'b1;
                    prv_waddr  = head_reg;
                    prv_wdata  = slot_reg;
                    head_next  = slot_reg;
                    count_next = count_reg + 1'b1;
                    state_next = S_FINISH;
                end
                else
                begin
                    // Link the new slot between before and cur
                    prv_we     = 1'b1;
                    prv_waddr  = slot_reg;
                    prv_wdata  = before_reg;
                    nxt_we     = 1'b1;
                    nxt_waddr  = slot_reg;
                    nxt_wdata  = cur_reg;
                    state_next = S_LINK;
                end
            end

            S_LINK:
            begin
                nxt_we     = 1'b1;
                nxt_waddr  = before_reg;
                nxt_wdata  = slot_reg;
                prv_we     = 1'b1;
                prv_waddr  = cur_reg;
                prv_wdata  = slot_reg;
                count_next = count_reg + 1'b1;
                state_next = S_FINISH;
            end

            S_POP:
            begin
                res_removed_next = val_rdata;
                if (cmd_reg == CMD_POP_FRONT)
                begin
                    head_next = nxt_rdata;
                end
                else
                begin
                    tail_next = prv_rdata;
                end
                count_next = count_reg - 1'b1;
                if (count_reg == CW'(1))
                begin
                    head_next = '0;
                    tail_next = '0;
                end
                // Return the slot to the free stack
                free_we    = 1'b1;
                free_waddr = fstk_reg[AW-1:0];
                free_wdata = slot_reg;
                fstk_next  = fstk_reg + 1'b1;
                state_next = S_FINISH;
            end

            S_FINISH:
            begin
                // Hold until the output register is free
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = OUT_W'({count_reg, res_removed_reg, res_status_reg});
                    state_next    = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Checks
    `BDQ_ASSERT_ALWAYS(a_count_bound, count_reg <= DEPTH_C, "entry count exceeds depth")
    `BDQ_ASSERT_IMPLY(a_slot_books, state_reg == S_IDLE, (count_reg + fstk_reg) == fresh_reg, "slot accounting mismatch")
    `BDQ_ASSERT_IMPLY(a_walk_range, state_reg == S_WALK, steps_reg < count_reg, "walk past list end")
    `BDQ_ASSERT_NEXT(a_busy_after_xfer, in_xfer, state_reg != S_IDLE, "idle right after transaction")

endmodule

@@ tb/bounded_deque_with_sorted_insert_tb.sv @@
// Self-checking testbench for the bounded deque with sorted insert.
// Needs bdq_pkg and the bounded_deque_with_sorted_insert RTL; nothing else.
// Directed table first, then random command mixes checked against a queue model.
module bounded_deque_with_sorted_insert_tb
    import bdq_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = BDQ_DEPTH_DEF;
    localparam int DW    = BDQ_DATA_WIDTH_DEF;
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int IN_W  = ((CMD_W + DW + 7) / 8) * 8;
    localparam int OUT_W = ((STATUS_W + DW + CW + 7) / 8) * 8;
    localparam int IN_PAD = IN_W - CMD_W - DW;

    localparam int          NUM_RANDOM     = 1700;
    localparam int          SEGMENT        = 40;
    localparam int          BURST_ITEMS    = 40;
    localparam int          SQUEEZE_CYCLES = 400;
    localparam int          DRAIN_CYCLES   = 60;
    localparam int unsigned MAX_CYCLES     = 1_000_000;
    localparam int          MAX_REPORTS    = 10;

    // Command codes the block must treat as no-ops
    localparam cmd_t CMD_SPARE_LO = 3'd5;
    localparam cmd_t CMD_SPARE_HI = 3'd7;

    typedef struct packed {
        status_t         status;
        logic [DW-1:0]   removed;
        logic [CW-1:0]   count;
    } deque_result_t;

    typedef struct packed {
        cmd_t            cmd;
        logic [DW-1:0]   value;
        logic [4:0]      reps;
        bit              typed;
        deque_result_t   want;
    } stim_row_t;

    localparam int NUM_DIRECTED = 12;

    // Rows with typed set carry their own expected result; the rest use the model
    localparam stim_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
        // pops and spare codes on an empty list
        '{CMD_POP_FRONT,  32'h0000_0000, 5'd1,  1'b1, '{ST_EMPTY, 32'd0, 5'd0}},
        '{CMD_POP_BACK,   32'hffff_ffff, 5'd1,  1'b1, '{ST_EMPTY, 32'd0, 5'd0}},
        '{CMD_SPARE_LO,   32'h1234_5678, 5'd1,  1'b1, '{ST_DONE,  32'd0, 5'd0}},
        '{CMD_SPARE_HI,   32'hedcb_a987, 5'd1,  1'b1, '{ST_DONE,  32'd0, 5'd0}},
        // value extremes at both ends
        '{CMD_PUSH_FRONT, 32'h7fff_ffff, 5'd1,  1'b1, '{ST_DONE,  32'd0, 5'd1}},
        '{CMD_PUSH_BACK,  32'h8000_0000, 5'd1,  1'b1, '{ST_DONE,  32'd0, 5'd2}},
        // second insert meets an equal value and must land in front of it
        '{CMD_SORTED,     32'h0000_0000, 5'd2,  1'b0, '0},
        '{CMD_POP_FRONT,  32'h5a5a_5a5a, 5'd1,  1'b0, '0},
        '{CMD_POP_BACK,   32'ha5a5_a5a5, 5'd1,  1'b0, '0},
        // fill the store, then knock on it
        '{CMD_PUSH_BACK,  32'h5555_5555, 5'd14, 1'b0, '0},
        '{CMD_PUSH_FRONT, 32'haaaa_aaaa, 5'd1,  1'b1, '{ST_FULL,  32'd0, 5'd16}},
        '{CMD_SORTED,     32'h0000_0000, 5'd1,  1'b1, '{ST_FULL,  32'd0, 5'd16}}
    };

    logic             clk      = 1'b0;
    logic             rst_n    = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata  = '0;    // cmd, value, zero pad
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;          // status, removed_value, count, zero pad

    // Model of the list contents, front at index 0
    logic [DW-1:0]    list_model [$];
    deque_result_t    pending_results [$];
    int unsigned      mismatches  = 0;
    int unsigned      cycle_count = 0;
    bit               squeeze_req = 1'b0;
    bit               rx_calm     = 1'b0;
    deque_result_t    got;
    deque_result_t    oldest;

    bounded_deque_with_sorted_insert dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #1ns clk = ~clk;

    // Apply one command to the list model and return what the block should report
    function automatic deque_result_t apply_command(input cmd_t cmd,
                                                    input logic [DW-1:0] value);
        deque_result_t res;
        int            pos;
        res = '0;
        res.status = ST_DONE;
        case (cmd)
            CMD_PUSH_FRONT, CMD_PUSH_BACK, CMD_SORTED:
            begin
                if (list_model.size() >= DEPTH)
                    res.status = ST_FULL;
                else if (cmd == CMD_PUSH_FRONT)
                    list_model.push_front(value);
                else if (cmd == CMD_PUSH_BACK)
                    list_model.push_back(value);
                else
                begin
                    // walk from the front past every strictly smaller entry
                    pos = 0;
                    while (pos < list_model.size() &&
                           $signed(list_model[pos]) < $signed(value))
                        pos++;
                    list_model.insert(pos, value);
                end
            end
            CMD_POP_FRONT, CMD_POP_BACK:
            begin
                if (list_model.size() == 0)
                    res.status = ST_EMPTY;
                else if (cmd == CMD_POP_FRONT)
                    res.removed = list_model.pop_front();
                else
                    res.removed = list_model.pop_back();
            end
            default:
                ;
        endcase
        res.count = CW'(list_model.size());
        return res;
    endfunction

    // Idle length: mostly none or short, now and then long
    function automatic int unsigned pick_gap(input bit calm);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (calm || roll < 50)
            return 0;
        if (roll < 88)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Offer one command, wait for the transaction, then log its expected result
    task automatic send_command(input cmd_t cmd, input logic [DW-1:0] value,
                                input bit typed, input deque_result_t want,
                                input int unsigned gap);
        deque_result_t predicted;
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{IN_PAD{1'b0}}, value, cmd};
        do
            @(posedge clk);
        while (!s_tready);
        predicted = apply_command(cmd, value);
        pending_results.push_back(typed ? want : predicted);
    endtask

    // Stimulus: reset, directed table, random mixes, drain
    initial
    begin
        int unsigned gap;
        int unsigned push_pct;
        int unsigned roll;
        bit          tx_calm;
        cmd_t        cmd;
        logic [DW-1:0] value;

        tx_calm = 1'b0;
        push_pct = 50;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED_ROWS[r])
        begin
            for (int k = 0; k < DIRECTED_ROWS[r].reps; k++)
                send_command(DIRECTED_ROWS[r].cmd, DIRECTED_ROWS[r].value,
                             DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].want,
                             pick_gap(1'b0));
        end

        // hold the receiver off while the sender keeps offering back to back
        squeeze_req = 1'b1;

        for (int n = 0; n < NUM_RANDOM; n++)
        begin
            // pick a fill bias per segment so the list swings between empty and full
            if (n % SEGMENT == 0)
            begin
                case ($urandom_range(0, 2))
                    0:       push_pct = 25;
                    1:       push_pct = 50;
                    default: push_pct = 78;
                endcase
                tx_calm = ($urandom_range(0, 4) == 0);
            end

            roll = $urandom_range(0, 99);
            if (roll < 3)
                cmd = cmd_t'(CMD_SPARE_LO + $urandom_range(0, 2));
            else if ($urandom_range(0, 99) < push_pct)
            begin
                case ($urandom_range(0, 3))
                    0:       cmd = CMD_PUSH_FRONT;
                    1:       cmd = CMD_PUSH_BACK;
                    default: cmd = CMD_SORTED;
                endcase
            end
            else
                cmd = ($urandom_range(0, 1) != 0) ? CMD_POP_FRONT : CMD_POP_BACK;

            // wide random values, a narrow band for ties, and the extremes
            roll = $urandom_range(0, 99);
            if (roll < 60)
                value = $urandom;
            else if (roll < 85)
                value = $urandom_range(0, 8) - 4;
            else
            begin
                case ($urandom_range(0, 3))
                    0:       value = 32'h8000_0000;
                    1:       value = 32'h7fff_ffff;
                    2:       value = '0;
                    default: value = '1;
                endcase
            end

            gap = (n < BURST_ITEMS) ? 0 : pick_gap(tx_calm);
            send_command(cmd, value, 1'b0, '0, gap);
        end
        s_tvalid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Receiver: random ready pattern, with one long hold-off on request
    initial
    begin
        int unsigned run;
        int unsigned gap;
        @(posedge clk);
        forever
        begin
            if (squeeze_req)
            begin
                m_tready <= 1'b0;
                repeat (SQUEEZE_CYCLES) @(posedge clk);
                squeeze_req = 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                run = $urandom_range(1, 24);
                repeat (run) @(posedge clk);
                gap = pick_gap(rx_calm);
                if (gap != 0)
                begin
                    m_tready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
                if ($urandom_range(0, 15) == 0)
                    rx_calm = ~rx_calm;
            end
        end
    end

    // Compare each result transaction with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            got.status  = m_tdata[STATUS_W-1:0];
            got.removed = m_tdata[STATUS_W +: DW];
            got.count   = m_tdata[STATUS_W + DW +: CW];
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result: status %0d removed %0d count %0d",
                             got.status, $signed(got.removed), got.count);
            end
            else
            begin
                oldest = pending_results.pop_front();
                if (got.status != oldest.status || got.removed != oldest.removed ||
                    got.count != oldest.count)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("mismatch: expected status %0d removed %0d count %0d, %s",
                                 oldest.status, $signed(oldest.removed), oldest.count,
                                 $sformatf("got status %0d removed %0d count %0d",
                                           got.status, $signed(got.removed), got.count));
                end
            end
        end
    end

    // Watchdog: give up after a generous number of cycles
    initial
    begin
        while (cycle_count < MAX_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Some tests failed");
        $finish;
    end

endmodule
